// ===== rtl/rhl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhl_pkg: shared constants and types for the header repair block
// Holds the header geometry, the logo table and the ring access request type.
// ----------------------------------------------------------------------------
package rhl_pkg;

    // Header geometry and repair positions.
    localparam logic [7:0] HEADER_LEN     = 8'd192;
    localparam logic [7:0] LOGO_CMP_START = 8'd4;
    localparam logic [7:0] LOGO_CMP_END   = 8'h9c;
    localparam logic [7:0] LOGO_FIX_END   = 8'ha0;
    localparam logic [7:0] COMP_POS       = 8'hbd;
    localparam logic [7:0] COMP_BIAS      = 8'h19;
    localparam logic [7:0] COMP_SUM_START = 8'ha0;

    // Ring geometry.
    localparam int unsigned RING_AW = 8;

    // Configuration register index (byte address bit 2).
    localparam logic REG_REPAIR_ENABLE = 1'b0;

    // Request kinds carried in tuser.
    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic               wr_en;
        logic [RING_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
        logic               rd_en;
        logic [RING_AW-1:0] rd_addr;
    } t_ring_req;

    localparam logic [7:0] LOGO_TABLE [0:159] = '{
        8'd46,  8'd0,   8'd0,   8'd234, 8'd36,  8'd255, 8'd174, 8'd81,
        8'd105, 8'd154, 8'd162, 8'd33,  8'd61,  8'd132, 8'd130, 8'd10,
        8'd132, 8'd228, 8'd9,   8'd173, 8'd17,  8'd36,  8'd139, 8'd152,
        8'd192, 8'd129, 8'd127, 8'd33,  8'd163, 8'd82,  8'd190, 8'd25,
        8'd147, 8'd9,   8'd206, 8'd32,  8'd16,  8'd70,  8'd74,  8'd74,
        8'd248, 8'd39,  8'd49,  8'd236, 8'd88,  8'd199, 8'd232, 8'd51,
        8'd130, 8'd227, 8'd206, 8'd191, 8'd133, 8'd244, 8'd223, 8'd148,
        8'd206, 8'd75,  8'd9,   8'd193, 8'd148, 8'd86,  8'd138, 8'd192,
        8'd19,  8'd114, 8'd167, 8'd252, 8'd159, 8'd132, 8'd77,  8'd115,
        8'd163, 8'd202, 8'd154, 8'd97,  8'd88,  8'd151, 8'd163, 8'd39,
        8'd252, 8'd3,   8'd152, 8'd118, 8'd35,  8'd29,  8'd199, 8'd97,
        8'd3,   8'd4,   8'd174, 8'd86,  8'd191, 8'd56,  8'd132, 8'd0,
        8'd64,  8'd167, 8'd14,  8'd253, 8'd255, 8'd82,  8'd254, 8'd3,
        8'd111, 8'd149, 8'd48,  8'd241, 8'd151, 8'd251, 8'd192, 8'd133,
        8'd96,  8'd214, 8'd128, 8'd37,  8'd169, 8'd99,  8'd190, 8'd3,
        8'd1,   8'd78,  8'd56,  8'd226, 8'd249, 8'd162, 8'd52,  8'd255,
        8'd187, 8'd62,  8'd3,   8'd68,  8'd120, 8'd0,   8'd144, 8'd203,
        8'd136, 8'd17,  8'd58,  8'd148, 8'd101, 8'd192, 8'd124, 8'd99,
        8'd135, 8'd240, 8'd60,  8'd175, 8'd214, 8'd37,  8'd228, 8'd139,
        8'd56,  8'd10,  8'd172, 8'd114, 8'd33,  8'd212, 8'd248, 8'd7
    };

    // Logo byte at a header position; positions past the table read as zero.
    function automatic logic [7:0] logo_byte(input logic [7:0] pos);
        logic [7:0] val;
        val = 8'd0;
        if (pos < LOGO_FIX_END) begin
            val = LOGO_TABLE[pos];
        end
        return val;
    endfunction

endpackage

// ===== rtl/rhl_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhl_ring: header delay ring
// A 192 x 8 memory with one write port and one registered read port.
// A read and a write to the same slot in one cycle return the old byte.
// ----------------------------------------------------------------------------
module rhl_ring
    import rhl_pkg::*;
(
    input  logic       i_clk,
    input  t_ring_req  i_req,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_mem [0:191];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/rom_header_logo_and_complement_fix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_header_logo_and_complement_fix: cartridge header repair stage
// Pipeline: a result is registered in stage 1, with the ring read register,
//   then in the output register before it leaves on the master side.
// Throughput: one input transfer per cycle while stage 1 is not held by a
//   stall; one ring read and one ring write port, at most one each per item.
// Reset (synchronous, active low) empties the ring and pipeline and sets
//   repair_enable to 1. Ring contents are not cleared; no slot is read
//   before it is written.
// ----------------------------------------------------------------------------
module rom_header_logo_and_complement_fix
    import rhl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser,   // [0] too_short
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration register.
    logic r_repair_en;

    // Header tracking state.
    logic [7:0] r_wr_slot,  n_wr_slot;
    logic [7:0] r_held,     n_held;
    logic [7:0] r_received, n_received;
    logic [7:0] r_emitted,  n_emitted;
    logic       r_mismatch, n_mismatch;
    logic [7:0] r_sum,      n_sum;

    // Stage 1: result waiting for the ring read data.
    logic       r_s1_valid;
    logic       r_s1_use_mem, n_s1_use_mem;
    logic [7:0] r_s1_byte,    n_s1_byte;
    logic       r_s1_last,    n_s1_last;
    logic       r_s1_short,   n_s1_short;
    logic       n_has_result;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_short;

    logic       out_free;
    logic       in_accept;
    logic       is_flush;
    logic [7:0] oldest_slot;
    logic [7:0] next_slot;
    logic       fix_sel;
    logic [7:0] fix_val;
    logic       note_hit;
    logic [7:0] ring_rd_data;
    t_ring_req  ring_req;
    logic       cfg_write;

    // ------------------------------------------------------------------------
    // Configuration port. Register 0 sits at byte address 0; bit 2 of the
    // address selects the register, so anything at address 4 and up misses.
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_REPAIR_ENABLE) ? {31'd0, r_repair_en} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repair_en <= 1'b1;
        end else if (cfg_write && (paddr[2] == REG_REPAIR_ENABLE)) begin
            r_repair_en <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------------
    // Handshake. Stage 1 moves into the output register whenever that
    // register is empty or being drained, so a new item is taken even while
    // a finished result still waits on the master side.
    // ------------------------------------------------------------------------
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_flush      = (s_axis_tuser[0] == REQ_FLUSH);

    // The oldest held byte sits held_count slots behind the write slot.
    always_comb begin
        if (r_wr_slot >= r_held) begin
            oldest_slot = r_wr_slot - r_held;
        end else begin
            oldest_slot = 8'({1'b0, r_wr_slot} + {1'b0, HEADER_LEN} - {1'b0, r_held});
        end
    end

    assign next_slot = (r_wr_slot == HEADER_LEN - 8'd1) ? 8'd0 : r_wr_slot + 8'd1;

    // Repair of the byte that leaves next, decided from its position. The
    // logo and the checksum are settled long before any header byte leaves,
    // so the replacement can be chosen here and the ring data muxed later.
    always_comb begin
        fix_sel = 1'b0;
        fix_val = 8'd0;
        if (r_repair_en) begin
            if (r_mismatch && (r_emitted >= LOGO_CMP_START) && (r_emitted < LOGO_FIX_END)) begin
                fix_sel = 1'b1;
                fix_val = logo_byte(r_emitted);
            end else if (r_emitted == COMP_POS) begin
                fix_sel = 1'b1;
                fix_val = 8'd0 - COMP_BIAS - r_sum;
            end
        end
    end

    assign note_hit = (r_received < HEADER_LEN);

    // ------------------------------------------------------------------------
    // Per-item control: state update, ring access and stage 1 result.
    // ------------------------------------------------------------------------
    always_comb begin
        n_wr_slot    = r_wr_slot;
        n_held       = r_held;
        n_received   = r_received;
        n_emitted    = r_emitted;
        n_mismatch   = r_mismatch;
        n_sum        = r_sum;
        n_has_result = 1'b0;
        n_s1_use_mem = 1'b0;
        n_s1_byte    = s_axis_tdata;
        n_s1_last    = 1'b0;
        n_s1_short   = 1'b0;
        ring_req     = '0;
        ring_req.wr_addr = r_wr_slot;
        ring_req.wr_data = s_axis_tdata;
        ring_req.rd_addr = oldest_slot;

        if (in_accept) begin
            if (!is_flush) begin
                if (!r_repair_en) begin
                    // Pass-through: the byte leaves as it came.
                    n_has_result = 1'b1;
                end else begin
                    if (r_held == HEADER_LEN) begin
                        // Ring full: the oldest byte is pushed out.
                        ring_req.rd_en = 1'b1;
                        n_has_result   = 1'b1;
                        n_s1_use_mem   = !fix_sel;
                        n_s1_byte      = fix_val;
                        if (r_emitted < HEADER_LEN) begin
                            n_emitted = r_emitted + 8'd1;
                        end
                    end else begin
                        n_held = r_held + 8'd1;
                    end
                    if (note_hit) begin
                        if ((r_received >= LOGO_CMP_START) && (r_received < LOGO_CMP_END)
                            && (s_axis_tdata != logo_byte(r_received))) begin
                            n_mismatch = 1'b1;
                        end
                        if ((r_received >= COMP_SUM_START) && (r_received < COMP_POS)) begin
                            n_sum = r_sum + s_axis_tdata;
                        end
                        n_received = r_received + 8'd1;
                    end
                    ring_req.wr_en = 1'b1;
                    n_wr_slot      = next_slot;
                end
            end else if (r_repair_en && note_hit) begin
                // Image ended before the whole header arrived.
                n_has_result = 1'b1;
                n_s1_byte    = 8'd0;
                n_s1_last    = 1'b1;
                n_s1_short   = 1'b1;
                n_wr_slot    = 8'd0;
                n_held       = 8'd0;
                n_received   = 8'd0;
                n_emitted    = 8'd0;
                n_mismatch   = 1'b0;
                n_sum        = 8'd0;
            end else if (r_held != 8'd0) begin
                // Drain one held byte.
                ring_req.rd_en = 1'b1;
                n_has_result   = 1'b1;
                n_s1_use_mem   = !fix_sel;
                n_s1_byte      = fix_val;
                n_held         = r_held - 8'd1;
                if (r_emitted < HEADER_LEN) begin
                    n_emitted = r_emitted + 8'd1;
                end
                if (r_held == 8'd1) begin
                    // Last byte of the image: start over for the next one.
                    n_s1_last  = 1'b1;
                    n_wr_slot  = 8'd0;
                    n_held     = 8'd0;
                    n_received = 8'd0;
                    n_emitted  = 8'd0;
                    n_mismatch = 1'b0;
                    n_sum      = 8'd0;
                end
            end
        end
    end

    rhl_ring u_ring (
        .i_clk     (i_clk),
        .i_req     (ring_req),
        .o_rd_data (ring_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot  <= 8'd0;
            r_held     <= 8'd0;
            r_received <= 8'd0;
            r_emitted  <= 8'd0;
            r_mismatch <= 1'b0;
            r_sum      <= 8'd0;
            r_s1_valid <= 1'b0;
        end else begin
            r_wr_slot  <= n_wr_slot;
            r_held     <= n_held;
            r_received <= n_received;
            r_emitted  <= n_emitted;
            r_mismatch <= n_mismatch;
            r_sum      <= n_sum;
            if (s_axis_tready) begin
                r_s1_valid <= in_accept && n_has_result;
            end
        end
    end

    // Stage 1 payload only changes when a new item enters.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_use_mem <= n_s1_use_mem;
            r_s1_byte    <= n_s1_byte;
            r_s1_last    <= n_s1_last;
            r_s1_short   <= n_s1_short;
        end
    end

    // ------------------------------------------------------------------------
    // Output register: picks the ring byte or the prepared byte.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_byte  <= r_s1_use_mem ? ring_rd_data : r_s1_byte;
            r_out_last  <= r_s1_last;
            r_out_short <= r_s1_short;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_byte;
    assign m_axis_tlast    = r_out_last;
    assign m_axis_tuser[0] = r_out_short;

endmodule

// ===== rtl/rhl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhl_checker: port-level checks for the header repair block
// Watches the stream and configuration ports and is bound to the top level.
// ----------------------------------------------------------------------------
module rhl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A too-short result is always a zero byte that closes the image.
    a_short_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'd0))
        else $error("too_short result is not a marked zero byte");

    // A stalled result keeps its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // Reset leaves no result on the master side.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result visible right after reset");

    // A write to the enable register reads back in the next cycle.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && !paddr[2] ##1 !paddr[2] |->
            prdata[0] == $past(pwdata[0]))
        else $error("repair_enable readback mismatch");

endmodule

bind rom_header_logo_and_complement_fix rhl_checker u_rhl_checker (.*);

// ===== dv/rom_header_logo_and_complement_fix_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_header_logo_and_complement_fix_tb: header repair stage testbench
// Streams cartridge images, short images, pass-through bursts and drain
// sequences into the block. A behavioral copy of the repair logic predicts
// every output transfer. A checker compares each output transfer, field by
// field, with the oldest prediction. Sender gaps and receiver stalls change
// from phase to phase.
// ----------------------------------------------------------------------------
module rom_header_logo_and_complement_fix_tb
    import rhl_pkg::*;
();

    // Header geometry, kept apart from the design package so that a wrong
    // constant in the design shows up as a mismatch.
    localparam int HDR_LEN     = 192;
    localparam int LOGO_CHK_LO = 4;
    localparam int LOGO_CHK_HI = 156;   // first position past the compare window
    localparam int LOGO_FIX_HI = 160;   // first position past the replaced range
    localparam int CSUM_LO     = 160;
    localparam int CSUM_POS    = 189;
    localparam logic [7:0] CSUM_BIAS = 8'h19;

    // Register map: repair_enable at byte address 0; address 4 holds nothing.
    localparam logic [2:0] ADDR_REPAIR_EN = 3'd0;
    localparam logic [2:0] ADDR_SPARE     = 3'd4;

    localparam int PHASE_ITEMS    = 290;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [7:0] HDR_LOGO [LOGO_FIX_HI] = '{
        8'd46,  8'd0,   8'd0,   8'd234, 8'd36,  8'd255, 8'd174, 8'd81,
        8'd105, 8'd154, 8'd162, 8'd33,  8'd61,  8'd132, 8'd130, 8'd10,
        8'd132, 8'd228, 8'd9,   8'd173, 8'd17,  8'd36,  8'd139, 8'd152,
        8'd192, 8'd129, 8'd127, 8'd33,  8'd163, 8'd82,  8'd190, 8'd25,
        8'd147, 8'd9,   8'd206, 8'd32,  8'd16,  8'd70,  8'd74,  8'd74,
        8'd248, 8'd39,  8'd49,  8'd236, 8'd88,  8'd199, 8'd232, 8'd51,
        8'd130, 8'd227, 8'd206, 8'd191, 8'd133, 8'd244, 8'd223, 8'd148,
        8'd206, 8'd75,  8'd9,   8'd193, 8'd148, 8'd86,  8'd138, 8'd192,
        8'd19,  8'd114, 8'd167, 8'd252, 8'd159, 8'd132, 8'd77,  8'd115,
        8'd163, 8'd202, 8'd154, 8'd97,  8'd88,  8'd151, 8'd163, 8'd39,
        8'd252, 8'd3,   8'd152, 8'd118, 8'd35,  8'd29,  8'd199, 8'd97,
        8'd3,   8'd4,   8'd174, 8'd86,  8'd191, 8'd56,  8'd132, 8'd0,
        8'd64,  8'd167, 8'd14,  8'd253, 8'd255, 8'd82,  8'd254, 8'd3,
        8'd111, 8'd149, 8'd48,  8'd241, 8'd151, 8'd251, 8'd192, 8'd133,
        8'd96,  8'd214, 8'd128, 8'd37,  8'd169, 8'd99,  8'd190, 8'd3,
        8'd1,   8'd78,  8'd56,  8'd226, 8'd249, 8'd162, 8'd52,  8'd255,
        8'd187, 8'd62,  8'd3,   8'd68,  8'd120, 8'd0,   8'd144, 8'd203,
        8'd136, 8'd17,  8'd58,  8'd148, 8'd101, 8'd192, 8'd124, 8'd99,
        8'd135, 8'd240, 8'd60,  8'd175, 8'd214, 8'd37,  8'd228, 8'd139,
        8'd56,  8'd10,  8'd172, 8'd114, 8'd33,  8'd212, 8'd248, 8'd7
    };

    // One predicted output transfer.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_last;
        logic       short_flag;
    } t_fixed_out;

    // Every input of the block starts at a known value.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic [0:0]  s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    rom_header_logo_and_complement_fix u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
        .s_axis_tuser  (s_axis_tuser),   // [0] req_type
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),   // [0] too_short
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow copy of the block's state.
    logic       repair_on;
    logic [7:0] ring_copy [HDR_LEN];
    logic [7:0] ring_wr;
    logic [7:0] ring_held;
    logic [7:0] hdr_seen;      // header bytes received, stops at HDR_LEN
    logic [7:0] hdr_emitted;   // bytes emitted, stops at HDR_LEN
    logic       logo_bad;
    logic [7:0] comp_acc;

    t_fixed_out repaired_q [$];

    int err_count     = 0;
    int items_sent    = 0;
    int image_count   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles   = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor of the repair logic.
    // ------------------------------------------------------------------------

    // Empties the image state; the register keeps its value.
    task automatic clear_image_state();
        ring_wr     = 8'd0;
        ring_held   = 8'd0;
        hdr_seen    = 8'd0;
        hdr_emitted = 8'd0;
        logo_bad    = 1'b0;
        comp_acc    = 8'd0;
    endtask

    // Tracks the logo compare and the complement sum over the header.
    task automatic note_header(input logic [7:0] b);
        int idx;
        idx = int'(hdr_seen);
        if (idx < HDR_LEN) begin
            if (idx >= LOGO_CHK_LO && idx < LOGO_CHK_HI && b != HDR_LOGO[idx]) begin
                logo_bad = 1'b1;
            end
            if (idx >= CSUM_LO && idx < CSUM_POS) begin
                comp_acc = comp_acc + b;
            end
            hdr_seen = hdr_seen + 8'd1;
        end
    endtask

    // Pulls the oldest held byte and repairs it by its image position.
    function automatic logic [7:0] pull_oldest(input logic fix);
        int         slot;
        int         pos;
        logic [7:0] b;
        slot = (int'(ring_wr) + HDR_LEN - int'(ring_held)) % HDR_LEN;
        b    = ring_copy[slot];
        pos  = int'(hdr_emitted);
        if (fix) begin
            if (logo_bad && pos >= LOGO_CHK_LO && pos < LOGO_FIX_HI) begin
                b = HDR_LOGO[pos];
            end else if (pos == CSUM_POS) begin
                b = 8'h00 - CSUM_BIAS - comp_acc;
            end
        end
        if (pos < HDR_LEN) begin
            hdr_emitted = hdr_emitted + 8'd1;
        end
        return b;
    endfunction

    task automatic push_ring(input logic [7:0] b);
        ring_copy[ring_wr] = b;
        ring_wr = (int'(ring_wr) == HDR_LEN - 1) ? 8'd0 : ring_wr + 8'd1;
    endtask

    task automatic predict_header_fix(input logic kind, input logic [7:0] b);
        logic [7:0] o;
        if (kind == REQ_DATA) begin
            if (!repair_on) begin
                repaired_q.push_back('{b, 1'b0, 1'b0});
            end else if (int'(ring_held) < HDR_LEN) begin
                note_header(b);
                push_ring(b);
                ring_held = ring_held + 8'd1;
            end else begin
                // Ring full: the new byte pushes the oldest one out.
                o = pull_oldest(1'b1);
                note_header(b);
                push_ring(b);
                repaired_q.push_back('{o, 1'b0, 1'b0});
            end
        end else begin
            if (repair_on && int'(hdr_seen) < HDR_LEN) begin
                clear_image_state();
                repaired_q.push_back('{8'd0, 1'b1, 1'b1});
            end else if (ring_held != 8'd0) begin
                o = pull_oldest(repair_on);
                ring_held = ring_held - 8'd1;
                if (ring_held == 8'd0) begin
                    clear_image_state();
                    repaired_q.push_back('{o, 1'b1, 1'b0});
                end else begin
                    repaired_q.push_back('{o, 1'b0, 1'b0});
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------------

    // Offers one item on the slave side and returns at the edge of its
    // transfer, or after the sender gap that follows it. Called at a rising
    // edge. tvalid stays high when the next item follows at once, so it is
    // never lowered and raised in one time step.
    task automatic send_item(input logic kind, input logic [7:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        // Flushes on an empty ring with repair off are ignored by the block.
        if (!(kind == REQ_FLUSH && !repair_on && ring_held == 8'd0)) begin
            items_sent++;
        end
        predict_header_fix(kind, b);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Stops sending, waits for every predicted transfer, then lets the
    // pipeline settle, since an item with no result may still be in flight.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (repaired_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_xfer(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (wr && addr == ADDR_REPAIR_EN) begin
            repair_on = wdata[0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes repair_enable with random upper bits and reads it back.
    task automatic set_repair(input logic on);
        logic [31:0] w;
        logic [31:0] r;
        w    = $urandom;
        w[0] = on;
        apb_xfer(1'b1, ADDR_REPAIR_EN, w, r);
        apb_xfer(1'b0, ADDR_REPAIR_EN, 32'd0, r);
        if (r[0] !== on) begin
            $error("repair_enable: expected %0d, got %0d", on, r[0]);
            err_count++;
        end
    endtask

    // The receiver stalls at random, with a rate set per phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Checker: every master-side transfer against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_fixed_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (repaired_q.size() == 0) begin
                $error("unexpected transfer: out_byte %0h last_byte %0d too_short %0d",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                err_count++;
            end else begin
                want = repaired_q.pop_front();
                if (m_axis_tdata !== want.byte_val) begin
                    $error("out_byte: expected %0h, got %0h", want.byte_val, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tlast !== want.is_last) begin
                    $error("last_byte: expected %0d, got %0d", want.is_last, m_axis_tlast);
                    err_count++;
                end
                if (m_axis_tuser[0] !== want.short_flag) begin
                    $error("too_short: expected %0d, got %0d",
                           want.short_flag, m_axis_tuser[0]);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // A flush on an empty image, and a short image of extreme bytes, each
    // give a single too_short transfer.
    task automatic test_too_short_images();
        send_item(REQ_FLUSH, 8'hff);
        send_item(REQ_DATA, 8'h00);
        send_item(REQ_DATA, 8'hff);
        send_item(REQ_FLUSH, 8'h00);
        wait_idle();
    endtask

    // With repair off, data passes at once and a flush with nothing held
    // gives no transfer.
    task automatic test_bypass_data();
        set_repair(1'b0);
        send_item(REQ_DATA, 8'h00);
        send_item(REQ_DATA, 8'hff);
        send_item(REQ_DATA, 8'h5a);
        send_item(REQ_DATA, 8'ha5);
        send_item(REQ_FLUSH, 8'h00);
        wait_idle();
        set_repair(1'b1);
    endtask

    // Bytes held with repair on, then drained with repair off: data passes
    // around them, they leave unrepaired and the final one is marked.
    task automatic test_bypass_drain_of_held_bytes();
        send_item(REQ_DATA, 8'h11);
        send_item(REQ_DATA, 8'h22);
        send_item(REQ_DATA, 8'h33);
        wait_idle();
        set_repair(1'b0);
        send_item(REQ_DATA, 8'hee);
        send_item(REQ_FLUSH, 8'h00);
        send_item(REQ_FLUSH, 8'h00);
        send_item(REQ_FLUSH, 8'h00);
        send_item(REQ_FLUSH, 8'h00);
        wait_idle();
        set_repair(1'b1);
    endtask

    // A write to the unused address must leave repair on.
    task automatic test_spare_register_ignored();
        logic [31:0] r;
        apb_xfer(1'b1, ADDR_SPARE, 32'd0, r);
        apb_xfer(1'b0, ADDR_REPAIR_EN, 32'd0, r);
        if (r[0] !== repair_on) begin
            $error("repair_enable: expected %0d, got %0d", repair_on, r[0]);
            err_count++;
        end
        send_item(REQ_DATA, 8'h80);
        send_item(REQ_FLUSH, 8'h00);
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Random sequences.
    // ------------------------------------------------------------------------

    // A full image: header of a kind that rotates from image to image, a few
    // bytes past it, then a drain with the odd data byte between flushes.
    // Kinds: exact logo; one logo byte wrong inside the compare window; one
    // wrong just outside it (no repair); random content throughout.
    task automatic send_full_image();
        int         kind_sel;
        int         bad_pos;
        int         total;
        int         extra_data;
        int         r;
        logic [7:0] b;
        kind_sel = image_count % 4;
        image_count++;
        total = HDR_LEN + $urandom_range(0, 6);
        bad_pos = -1;
        if (kind_sel == 1) begin
            bad_pos = $urandom_range(LOGO_CHK_LO, LOGO_CHK_HI - 1);
        end else if (kind_sel == 2) begin
            r = $urandom_range(0, 7);
            bad_pos = (r < 4) ? r : LOGO_CHK_HI - 4 + r;
        end
        for (int p = 0; p < total; p++) begin
            if (p < LOGO_FIX_HI && kind_sel != 3) begin
                b = HDR_LOGO[p];
                if (p == bad_pos) begin
                    b = b ^ 8'($urandom_range(1, 255));
                end
            end else begin
                b = 8'($urandom);
            end
            send_item(REQ_DATA, b);
        end
        extra_data = 0;
        while (ring_held != 8'd0) begin
            if (extra_data < 4 && $urandom_range(0, 9) == 0) begin
                extra_data++;
                send_item(REQ_DATA, 8'($urandom));
            end else begin
                send_item(REQ_FLUSH, 8'($urandom));
            end
        end
    endtask

    // An image cut off before the header ends; mostly tiny, sometimes long.
    task automatic send_short_image();
        int r;
        int len;
        r = $urandom_range(0, 9);
        len = (r == 0) ? HDR_LEN - 1 : (r == 1) ? $urandom_range(13, HDR_LEN - 2)
                                                : $urandom_range(1, 12);
        for (int p = 0; p < len; p++) begin
            send_item(REQ_DATA, (p < LOGO_FIX_HI && r[0]) ? HDR_LOGO[p] : 8'($urandom));
        end
        send_item(REQ_FLUSH, 8'($urandom));
    endtask

    // A burst with repair off: data and stray flushes.
    task automatic send_bypass_burst();
        int n;
        wait_idle();
        set_repair(1'b0);
        n = $urandom_range(5, 30);
        for (int k = 0; k < n; k++) begin
            send_item(($urandom_range(0, 4) == 0) ? REQ_FLUSH : REQ_DATA, 8'($urandom));
        end
        wait_idle();
        set_repair(1'b1);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input int n_items);
        int first;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first = items_sent;
        while (items_sent - first < n_items) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_full_image();
            end else if (pick < 80) begin
                send_short_image();
            end else if (pick < 92) begin
                send_bypass_burst();
            end else begin
                send_item(REQ_FLUSH, 8'($urandom));
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repair_on = 1'b1;
        clear_image_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_too_short_images();
        test_bypass_data();
        test_bypass_drain_of_held_bytes();
        test_spare_register_ignored();

        run_random_phase(0, 0, PHASE_ITEMS);
        run_random_phase(79, 0, PHASE_ITEMS);
        run_random_phase(0, 79, PHASE_ITEMS);
        run_random_phase(32, 32, PHASE_ITEMS);

        // wait_idle in the last phase drained the predictions; a few more
        // cycles catch any stray output transfer.
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
